// ===== rtl/gravity_vector_complementary_filter_macros.svh =====
// assertion macros for the gravity vector filter
// expects aclk and aresetn in the scope where a macro is used
`ifndef GRAVITY_VECTOR_COMPLEMENTARY_FILTER_MACROS_SVH
`define GRAVITY_VECTOR_COMPLEMENTARY_FILTER_MACROS_SVH

// consequent checked in the same cycle
`define GVCF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define GVCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gvcf_pkg.sv =====
// shared widths, register codes, reset values and helper functions
// of the gravity vector filter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gvcf_pkg;

    localparam int SFB_DEFAULT = 28;

    localparam int ST_W     = 32;
    localparam int LP_W     = 24;
    localparam int ALPHA_W  = 16;
    localparam int ACCLIM_W = 15;
    localparam int RATE_W   = 24;
    localparam int ACC_W    = 16;
    localparam int OUT_W    = 16;
    localparam int MAG_W    = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GROUND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_AIR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PREFILT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX      = 3'd5;

    localparam logic [LP_W-1:0]     RST_LOOP_PERIOD   = 24'd16777;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_GROUND  = 16'd64880;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_AIR     = 16'd65470;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_PREFILT = 16'd0;
    localparam logic [ACCLIM_W-1:0] RST_ACCEL_MIN     = 15'd2867;
    localparam logic [ACCLIM_W-1:0] RST_ACCEL_MAX     = 15'd5325;

    // cordic
    localparam int CORDIC_ITERS = 16;
    localparam int CX_W         = 36;
    localparam int Z_W          = 20;
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

    typedef logic signed [ST_W-1:0] sword_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:    return 20'sd51472;
            4'd1:    return 20'sd30385;
            4'd2:    return 20'sd16055;
            4'd3:    return 20'sd8150;
            4'd4:    return 20'sd4091;
            4'd5:    return 20'sd2047;
            4'd6:    return 20'sd1024;
            4'd7:    return 20'sd512;
            4'd8:    return 20'sd256;
            4'd9:    return 20'sd128;
            4'd10:   return 20'sd64;
            4'd11:   return 20'sd32;
            4'd12:   return 20'sd16;
            4'd13:   return 20'sd8;
            4'd14:   return 20'sd4;
            default: return 20'sd2;
        endcase
    endfunction

    function automatic sword_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gvcf_sqrt.sv =====
// bit-serial floor square root, two radicand bits per cycle
// depends on gvcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvcf_sqrt
    import gvcf_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire  [63:0]      radicand,
    output logic             done,
    output logic [MAG_W-1:0] root
);

    logic [63:0]      rad_reg, rad_next;
    logic [34:0]      rem_reg, rem_next;
    logic [MAG_W-1:0] root_reg, root_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [34:0]      rem_sh;
    logic [34:0]      trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/gvcf_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit quotient
// caller keeps the quotient below 2^32; depends on gvcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvcf_div
    import gvcf_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire  [63:0]      num,
    input  wire  [MAG_W-1:0] den,
    output logic             done,
    output logic [31:0]      quo
);

    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      low_reg, low_next;
    logic [MAG_W-1:0] den_reg, den_next;
    logic [31:0]      quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      rs;

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rs        = {rem_reg, low_reg[31]};
        if (start) begin
            rem_next  = num[63:32];
            low_next  = num[31:0];
            den_next  = den;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            low_next = {low_reg[30:0], 1'b0};
            if (rs >= {1'b0, den_reg}) begin
                rem_next = 32'(rs - {1'b0, den_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = rs[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/gvcf_cordic.sv =====
// vectoring cordic for atan2(y, x), one micro-rotation per cycle
// result in radians q3.12; depends on gvcf_pkg
`timescale 1ns / 1ps
`default_nettype none

module gvcf_cordic
    import gvcf_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire  signed [ST_W-1:0]  y_in,
    input  wire  signed [ST_W-1:0]  x_in,
    output logic                    done,
    output logic signed [OUT_W-1:0] angle
);

    logic signed [CX_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic [3:0]              it_reg, it_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [OUT_W-1:0] angle_reg, angle_next;
    logic signed [CX_W-1:0]  xs, ys, dx, dy;

    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        xs         = CX_W'(x_in);
        ys         = CX_W'(y_in);
        dx         = y_reg >>> it_reg;
        dy         = x_reg >>> it_reg;
        if (start) begin
            it_next = '0;
            if (x_in == '0 && y_in == '0) begin
                // both operands zero: angle is zero
                angle_next = '0;
                done_next  = 1'b1;
            end else begin
                busy_next = 1'b1;
                if (xs < 0) begin
                    if (ys >= 0) begin
                        x_next = ys;
                        y_next = -xs;
                        z_next = HALF_PI_Q16;
                    end else begin
                        x_next = -ys;
                        y_next = xs;
                        z_next = -HALF_PI_Q16;
                    end
                end else begin
                    x_next = xs;
                    y_next = ys;
                    z_next = '0;
                end
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_q16(it_reg);
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_q16(it_reg);
            end
            it_next = it_reg + 4'd1;
            if (it_reg == 4'(CORDIC_ITERS - 1)) begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                angle_next = sat16((64'(z_next) + 64'sd8) >>> 4);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

`default_nettype wire

// ===== rtl/gravity_vector_complementary_filter.sv =====
// gravity vector complementary filter: item sequencer, shared multiplier,
// state registers and output register; uses gvcf_pkg, gvcf_sqrt, gvcf_div,
// gvcf_cordic and the assertion macro header
//
// usage
//  - s_ channel carries one imu sample per request: three gyro rates and
//    three accel axes in s_tdata, the on-ground flag in s_tuser
//  - m_ channel returns one result per sample: gravity estimate and two
//    tilt angles in m_tdata, the fusion flag in m_tuser
//  - registers are written through cfg_we / cfg_index / cfg_wdata; users write
//    only while no sample is in flight (unchecked); unknown indexes are ignored
//  - one sample is processed at a time, s_tready is high only when idle
//  - time from accept to m_tvalid depends on whether the accel is rejected or
//    fuses and on whether the sample is on the ground or in flight
//  - the square root and divide units run 32 steps per call and the cordic
//    16 steps per angle; the multiplier product is registered
//  - the finished result sits in an output register; a new sample is taken
//    while it waits, and the next result holds in the sequencer until the
//    receiver takes the first one
//  - reset (aresetn low, synchronous) loads register defaults, sets the
//    estimate to (0, 0, 1 g) and clears the accel prefilter
`timescale 1ns / 1ps
`default_nettype none
`include "gravity_vector_complementary_filter_macros.svh"

module gravity_vector_complementary_filter
    import gvcf_pkg::*;
#(
    parameter int STATE_FRAC_BITS = SFB_DEFAULT
)
(
    input  wire                   aclk,
    input  wire                   aresetn,
    // input samples
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // rate_x, rate_y, rate_z (24 bit each), acc_x, acc_y, acc_z (16 bit each)
    input  wire  [119:0]          s_tdata,
    // on_ground
    input  wire  [0:0]            s_tuser,
    // results
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // grav_x, grav_y, grav_z, tilt_a, tilt_b (16 bit each)
    output logic [79:0]           m_tdata,
    // fused
    output logic [0:0]            m_tuser,
    // register writes
    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

    // fixed point shifts derived from the state fraction width
    localparam int D_SHIFT   = 40 - STATE_FRAC_BITS;
    localparam int A_SHIFT   = STATE_FRAC_BITS - 12;
    localparam sword_t ONE_G = sword_t'(64'sd1 <<< STATE_FRAC_BITS);

    // sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DMUL  = 5'd1;
    localparam logic [4:0] ST_DACC  = 5'd2;
    localparam logic [4:0] ST_RMUL  = 5'd3;
    localparam logic [4:0] ST_RACC  = 5'd4;
    localparam logic [4:0] ST_BMUL1 = 5'd5;
    localparam logic [4:0] ST_BMUL2 = 5'd6;
    localparam logic [4:0] ST_BACC  = 5'd7;
    localparam logic [4:0] ST_SQ    = 5'd8;
    localparam logic [4:0] ST_SQACC = 5'd9;
    localparam logic [4:0] ST_SQST  = 5'd10;
    localparam logic [4:0] ST_SQW   = 5'd11;
    localparam logic [4:0] ST_WIN   = 5'd12;
    localparam logic [4:0] ST_DIVS  = 5'd13;
    localparam logic [4:0] ST_DIVW  = 5'd14;
    localparam logic [4:0] ST_TAS   = 5'd15;
    localparam logic [4:0] ST_TAW   = 5'd16;
    localparam logic [4:0] ST_TBS   = 5'd17;
    localparam logic [4:0] ST_TBW   = 5'd18;
    localparam logic [4:0] ST_DONE  = 5'd19;

    // blend flavor and magnitude target
    localparam logic BM_PREFILT = 1'b0;
    localparam logic BM_FUSE    = 1'b1;
    localparam logic MP_ACCEL   = 1'b0;
    localparam logic MP_GRAV    = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [2:0] ROT_LAST = 3'd5;

    // one small-angle rotation step: target += or -= d[dsel] * g[ssel]
    typedef struct packed {
        logic [1:0] dsel;
        logic [1:0] ssel;
        logic [1:0] tsel;
        logic       sub;
    } rot_sel_t;

    function automatic rot_sel_t rot_sel(input logic [2:0] s);
        case (s)
            3'd0:    return '{dsel: AX_X, ssel: AX_X, tsel: AX_Z, sub: 1'b1};
            3'd1:    return '{dsel: AX_X, ssel: AX_Z, tsel: AX_X, sub: 1'b0};
            3'd2:    return '{dsel: AX_Y, ssel: AX_Z, tsel: AX_Y, sub: 1'b0};
            3'd3:    return '{dsel: AX_Y, ssel: AX_Y, tsel: AX_Z, sub: 1'b1};
            3'd4:    return '{dsel: AX_Z, ssel: AX_Y, tsel: AX_X, sub: 1'b1};
            default: return '{dsel: AX_Z, ssel: AX_X, tsel: AX_Y, sub: 1'b0};
        endcase
    endfunction

    // configuration registers
    logic [LP_W-1:0]     lp_reg;
    logic [ALPHA_W-1:0]  ag_reg, aa_reg, apf_reg;
    logic [ACCLIM_W-1:0] amin_reg, amax_reg;

    // sequencer control
    logic [4:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [2:0] rstep_reg, rstep_next;
    logic       bmode_reg, bmode_next;
    logic       mpass_reg, mpass_next;
    logic       ground_reg, ground_next;
    logic       fused_reg, fused_next;
    logic       vneg_reg, vneg_next;

    // working values
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [RATE_W-1:0] rate_next [3];
    sword_t a_reg [3], a_next [3];
    sword_t s_reg [3], s_next [3];
    sword_t g_reg [3], g_next [3];
    sword_t d_reg [3], d_next [3];
    sword_t q_reg, q_next;
    logic signed [63:0]      bacc_reg, bacc_next;
    logic [63:0]             sum_reg, sum_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic signed [OUT_W-1:0] tilt_a_reg, tilt_a_next, tilt_b_reg, tilt_b_next;

    // shared multiplier, product registered every cycle
    sword_t             mul_a, mul_b;
    logic signed [63:0] p_reg;

    // output register
    logic        mv_reg, mv_next;
    logic [79:0] mdata_reg, mdata_next;
    logic        muser_reg, muser_next;

    // unpacked input fields
    logic signed [RATE_W-1:0] in_rate [3];
    logic signed [ACC_W-1:0]  in_acc [3];

    // iterative units
    logic               sqrt_start, sqrt_done;
    logic [MAG_W-1:0]   sqrt_root;
    logic               div_start, div_done;
    logic [63:0]        div_num;
    logic [MAG_W-1:0]   div_den;
    logic [31:0]        div_quo;
    logic               cor_start, cor_done;
    sword_t             cor_y;
    logic signed [OUT_W-1:0] cor_angle;

    // helpers
    rot_sel_t           rot;
    logic [ALPHA_W-1:0] coef;
    logic [16:0]        coef_c;
    sword_t             vsel;
    logic signed [32:0] vs33;
    logic [31:0]        vabs;
    logic signed [63:0] bsum;
    logic [33:0]        win_lo, win_hi;
    sword_t             qsig;

    assign in_rate[0] = s_tdata[23:0];
    assign in_rate[1] = s_tdata[47:24];
    assign in_rate[2] = s_tdata[71:48];
    assign in_acc[0]  = s_tdata[87:72];
    assign in_acc[1]  = s_tdata[103:88];
    assign in_acc[2]  = s_tdata[119:104];

    assign rot    = rot_sel(rstep_reg);
    assign coef   = (bmode_reg == BM_PREFILT) ? apf_reg : (ground_reg ? ag_reg : aa_reg);
    assign coef_c = 17'h10000 - {1'b0, coef};
    assign vsel   = (mpass_reg == MP_GRAV) ? g_reg[idx_reg] : a_reg[idx_reg];
    assign vs33   = 33'(vsel);
    assign vabs   = vs33[32] ? 32'(-vs33) : 32'(vs33);
    assign bsum   = bacc_reg + p_reg;
    assign win_lo = 34'(amin_reg) << A_SHIFT;
    assign win_hi = 34'(amax_reg) << A_SHIFT;
    assign qsig   = vneg_reg ? -sword_t'(div_quo) : sword_t'(div_quo);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DMUL: begin
                mul_a = sword_t'(rate_reg[idx_reg]);
                mul_b = sword_t'({8'd0, lp_reg});
            end
            ST_RMUL: begin
                mul_a = d_reg[rot.dsel];
                mul_b = g_reg[rot.ssel];
            end
            ST_BMUL1: begin
                mul_a = (bmode_reg == BM_FUSE) ? g_reg[idx_reg] : s_reg[idx_reg];
                mul_b = sword_t'({16'd0, coef});
            end
            ST_BMUL2: begin
                mul_a = (bmode_reg == BM_FUSE) ? q_reg : a_reg[idx_reg];
                mul_b = sword_t'({15'd0, coef_c});
            end
            ST_SQ: begin
                mul_a = vsel;
                mul_b = vsel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
    end

    // unit requests
    assign sqrt_start = (state_reg == ST_SQST);
    assign div_start  = (state_reg == ST_DIVS);
    assign div_num    = (64'(vabs) << STATE_FRAC_BITS) + 64'(mag_reg >> 1);
    assign div_den    = mag_reg;
    assign cor_start  = (state_reg == ST_TAS) || (state_reg == ST_TBS);
    assign cor_y      = (state_reg == ST_TBS) ? g_reg[AX_Y] : g_reg[AX_X];

    gvcf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    gvcf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    gvcf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .y_in    (cor_y),
        .x_in    (g_reg[AX_Z]),
        .done    (cor_done),
        .angle   (cor_angle)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rstep_next  = rstep_reg;
        bmode_next  = bmode_reg;
        mpass_next  = mpass_reg;
        ground_next = ground_reg;
        fused_next  = fused_reg;
        vneg_next   = vneg_reg;
        rate_next   = rate_reg;
        a_next      = a_reg;
        s_next      = s_reg;
        g_next      = g_reg;
        d_next      = d_reg;
        q_next      = q_reg;
        bacc_next   = bacc_reg;
        sum_next    = sum_reg;
        mag_next    = mag_reg;
        tilt_a_next = tilt_a_reg;
        tilt_b_next = tilt_b_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mv_next     = mv_reg;
        if (m_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < 3; i++) begin
                        rate_next[i] = in_rate[i];
                        a_next[i]    = sat32(64'(in_acc[i]) <<< A_SHIFT);
                    end
                    ground_next = s_tuser[0];
                    fused_next  = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_DMUL;
                end
            end
            ST_DMUL: begin
                state_next = ST_DACC;
            end
            ST_DACC: begin
                // angle increment, q.40 down to state fraction
                d_next[idx_reg] = sat32((p_reg + (64'sd1 <<< (D_SHIFT - 1))) >>> D_SHIFT);
                if (idx_reg == AX_Z) begin
                    rstep_next = '0;
                    state_next = ST_RMUL;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DMUL;
                end
            end
            ST_RMUL: begin
                state_next = ST_RACC;
            end
            ST_RACC: begin
                if (rot.sub) begin
                    g_next[rot.tsel] = sat32(64'(g_reg[rot.tsel]) -
                        ((p_reg + (64'sd1 <<< (STATE_FRAC_BITS - 1))) >>> STATE_FRAC_BITS));
                end else begin
                    g_next[rot.tsel] = sat32(64'(g_reg[rot.tsel]) +
                        ((p_reg + (64'sd1 <<< (STATE_FRAC_BITS - 1))) >>> STATE_FRAC_BITS));
                end
                idx_next = '0;
                if (rstep_reg == ROT_LAST) begin
                    if (!ground_reg) begin
                        bmode_next = BM_PREFILT;
                        state_next = ST_BMUL1;
                    end else begin
                        mpass_next = MP_ACCEL;
                        sum_next   = '0;
                        state_next = ST_SQ;
                    end
                end else begin
                    rstep_next = rstep_reg + 3'd1;
                    state_next = ST_RMUL;
                end
            end
            ST_BMUL1: begin
                state_next = ST_BMUL2;
            end
            ST_BMUL2: begin
                bacc_next  = p_reg;
                state_next = ST_BACC;
            end
            ST_BACC: begin
                if (bmode_reg == BM_PREFILT) begin
                    s_next[idx_reg] = sat32((bsum + 64'sd32768) >>> 16);
                    a_next[idx_reg] = sat32((bsum + 64'sd32768) >>> 16);
                    if (idx_reg == AX_Z) begin
                        idx_next   = '0;
                        mpass_next = MP_ACCEL;
                        sum_next   = '0;
                        state_next = ST_SQ;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_BMUL1;
                    end
                end else begin
                    g_next[idx_reg] = sat32((bsum + 64'sd32768) >>> 16);
                    if (idx_reg == AX_Z) begin
                        idx_next = '0;
                        if (!ground_reg) begin
                            mpass_next = MP_GRAV;
                            sum_next   = '0;
                            state_next = ST_SQ;
                        end else begin
                            state_next = ST_TAS;
                        end
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_SQ: begin
                state_next = ST_SQACC;
            end
            ST_SQACC: begin
                sum_next = sum_reg + 64'(p_reg);
                if (idx_reg == AX_Z) begin
                    idx_next   = '0;
                    state_next = ST_SQST;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_SQ;
                end
            end
            ST_SQST: begin
                state_next = ST_SQW;
            end
            ST_SQW: begin
                if (sqrt_done) begin
                    mag_next = sqrt_root;
                    if (mpass_reg == MP_ACCEL) begin
                        state_next = ST_WIN;
                    end else if (sqrt_root != '0) begin
                        state_next = ST_DIVS;
                    end else begin
                        // zero estimate in flight keeps the vector as it is
                        state_next = ST_TAS;
                    end
                end
            end
            ST_WIN: begin
                // exclusive magnitude window
                if ({2'b00, mag_reg} > win_lo && {2'b00, mag_reg} < win_hi) begin
                    fused_next = 1'b1;
                    state_next = ST_DIVS;
                end else begin
                    state_next = ST_TAS;
                end
            end
            ST_DIVS: begin
                vneg_next  = vsel[ST_W-1];
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    if (mpass_reg == MP_ACCEL) begin
                        q_next     = qsig;
                        bmode_next = BM_FUSE;
                        state_next = ST_BMUL1;
                    end else begin
                        g_next[idx_reg] = qsig;
                        if (idx_reg == AX_Z) begin
                            state_next = ST_TAS;
                        end else begin
                            idx_next   = idx_reg + 2'd1;
                            state_next = ST_DIVS;
                        end
                    end
                end
            end
            ST_TAS: begin
                state_next = ST_TAW;
            end
            ST_TAW: begin
                if (cor_done) begin
                    tilt_a_next = cor_angle;
                    state_next  = ST_TBS;
                end
            end
            ST_TBS: begin
                state_next = ST_TBW;
            end
            ST_TBW: begin
                if (cor_done) begin
                    tilt_b_next = cor_angle;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = {tilt_b_reg, tilt_a_reg,
                        sat16((64'(g_reg[AX_Z]) + (64'sd1 <<< (A_SHIFT - 1))) >>> A_SHIFT),
                        sat16((64'(g_reg[AX_Y]) + (64'sd1 <<< (A_SHIFT - 1))) >>> A_SHIFT),
                        sat16((64'(g_reg[AX_X]) + (64'sd1 <<< (A_SHIFT - 1))) >>> A_SHIFT)};
                    muser_next = fused_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            rstep_reg <= '0;
            bmode_reg <= BM_PREFILT;
            mpass_reg <= MP_ACCEL;
            mv_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                s_reg[i] <= '0;
            end
            g_reg[AX_X] <= '0;
            g_reg[AX_Y] <= '0;
            g_reg[AX_Z] <= ONE_G;
            lp_reg   <= RST_LOOP_PERIOD;
            ag_reg   <= RST_ALPHA_GROUND;
            aa_reg   <= RST_ALPHA_AIR;
            apf_reg  <= RST_ALPHA_PREFILT;
            amin_reg <= RST_ACCEL_MIN;
            amax_reg <= RST_ACCEL_MAX;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rstep_reg <= rstep_next;
            bmode_reg <= bmode_next;
            mpass_reg <= mpass_next;
            mv_reg    <= mv_next;
            s_reg     <= s_next;
            g_reg     <= g_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOOP_PERIOD:   lp_reg   <= cfg_wdata;
                    CFG_ALPHA_GROUND:  ag_reg   <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ALPHA_AIR:     aa_reg   <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ALPHA_PREFILT: apf_reg  <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ACCEL_MIN:     amin_reg <= cfg_wdata[ACCLIM_W-1:0];
                    CFG_ACCEL_MAX:     amax_reg <= cfg_wdata[ACCLIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        ground_reg <= ground_next;
        fused_reg  <= fused_next;
        vneg_reg   <= vneg_next;
        rate_reg   <= rate_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        bacc_reg   <= bacc_next;
        sum_reg    <= sum_next;
        mag_reg    <= mag_next;
        tilt_a_reg <= tilt_a_next;
        tilt_b_reg <= tilt_b_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // checks
    `GVCF_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "accepted a request while busy")
    `GVCF_ASSERT_SAME(a_div_nonzero, div_start, div_den != '0, "divide started with zero magnitude")
    `GVCF_ASSERT_SAME(a_hold_only_when_full, state_reg == ST_DONE && $past(state_reg) == ST_DONE, m_tvalid, "result held with empty output register")

endmodule

`default_nettype wire

// ===== dv/gvcf_checker.sv =====
// watches the sample, result and register ports of the gravity vector filter,
// predicts each result from its own copy of the filter state and compares
// depends on gvcf_pkg for register codes, reset values and widths
`timescale 1ns / 1ps

module gvcf_checker
    import gvcf_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire  [119:0]          s_tdata,
    input  wire  [0:0]            s_tuser,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire  [79:0]           m_tdata,
    input  wire  [0:0]            m_tuser,
    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    pending
);

    localparam int SFB = SFB_DEFAULT;
    localparam longint ATAN_TBL [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                         512, 256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct packed {
        logic [79:0] fields;
        logic        fused;
    } grav_result_t;

    grav_result_t expected_grav_q[$];

    logic [LP_W-1:0]     loop_period;
    logic [ALPHA_W-1:0]  alpha_ground, alpha_air, alpha_prefilt;
    logic [ACCLIM_W-1:0] accel_min, accel_max;
    longint              grav_est [3];
    longint              acc_smooth [3];

    string field_name [5] = '{"grav_x", "grav_y", "grav_z", "tilt_a", "tilt_b"};

    function automatic longint rshr(input longint v, input int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clamp32(input longint v);
        return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint mix(input longint old, input longint nw, input longint a);
        return clamp32(rshr(old * a + nw * (65536 - a), 16));
    endfunction

    function automatic longint unsigned vec_norm(input longint v0, v1, v2);
        longint unsigned s, r, b, m;
        longint vv [3];
        vv = '{v0, v1, v2};
        s = 0;
        foreach (vv[i]) begin
            m = vv[i] < 0 ? -vv[i] : vv[i];
            s += m * m;
        end
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint to_unit(input longint v, input longint unsigned mag);
        longint unsigned m, q;
        m = longint'(v < 0 ? -v : v) << SFB;
        q = (m + mag / 2) / mag;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    // cordic vectoring, same quadrant fold and rounding as the block
    function automatic logic [15:0] angle_of(input longint y_in, input longint x_in);
        longint x, y, z, t, dx, dy;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(HALF_PI_Q16);
            end else begin
                t = x; x = -y; y = t; z = -longint'(HALF_PI_Q16);
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        return 16'(clamp(rshr(z, 4), -32768, 32767));
    endfunction

    function automatic grav_result_t filter_step(input logic [119:0] d, input logic gnd);
        grav_result_t res;
        longint ang [3];
        longint acc [3];
        longint unsigned mag, lo, hi, gm;
        longint coef;
        res.fused = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ang[i] = clamp32(rshr(longint'($signed(d[24*i +: 24])) * longint'(loop_period),
                                  40 - SFB));
            acc[i] = clamp32(longint'($signed(d[72 + 16*i +: 16])) * (longint'(1) <<< (SFB - 12)));
        end
        // small-angle rotation, each step uses the freshly updated axis
        grav_est[2] = clamp32(grav_est[2] - rshr(ang[0] * grav_est[0], SFB));
        grav_est[0] = clamp32(grav_est[0] + rshr(ang[0] * grav_est[2], SFB));
        grav_est[1] = clamp32(grav_est[1] + rshr(ang[1] * grav_est[2], SFB));
        grav_est[2] = clamp32(grav_est[2] - rshr(ang[1] * grav_est[1], SFB));
        grav_est[0] = clamp32(grav_est[0] - rshr(ang[2] * grav_est[1], SFB));
        grav_est[1] = clamp32(grav_est[1] + rshr(ang[2] * grav_est[0], SFB));
        if (!gnd) begin
            for (int i = 0; i < 3; i++) begin
                acc_smooth[i] = mix(acc_smooth[i], acc[i], longint'(alpha_prefilt));
                acc[i] = acc_smooth[i];
            end
        end
        mag = vec_norm(acc[0], acc[1], acc[2]);
        lo = longint'(accel_min) << (SFB - 12);
        hi = longint'(accel_max) << (SFB - 12);
        if (mag > lo && mag < hi) begin
            coef = gnd ? longint'(alpha_ground) : longint'(alpha_air);
            res.fused = 1'b1;
            for (int i = 0; i < 3; i++)
                grav_est[i] = mix(grav_est[i], to_unit(acc[i], mag), coef);
            if (!gnd) begin
                gm = vec_norm(grav_est[0], grav_est[1], grav_est[2]);
                if (gm != 0)
                    for (int i = 0; i < 3; i++)
                        grav_est[i] = clamp32(to_unit(grav_est[i], gm));
            end
        end
        for (int i = 0; i < 3; i++)
            res.fields[16*i +: 16] = 16'(clamp(rshr(grav_est[i], SFB - 12), -32768, 32767));
        res.fields[48 +: 16] = angle_of(grav_est[0], grav_est[2]);
        res.fields[64 +: 16] = angle_of(grav_est[1], grav_est[2]);
        return res;
    endfunction

    initial begin
        mismatch_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        grav_result_t want;
        if (!aresetn) begin
            loop_period   <= RST_LOOP_PERIOD;
            alpha_ground  <= RST_ALPHA_GROUND;
            alpha_air     <= RST_ALPHA_AIR;
            alpha_prefilt <= RST_ALPHA_PREFILT;
            accel_min     <= RST_ACCEL_MIN;
            accel_max     <= RST_ACCEL_MAX;
            grav_est   = '{0, 0, longint'(1) <<< SFB};
            acc_smooth = '{0, 0, 0};
            expected_grav_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOOP_PERIOD:   loop_period   <= cfg_wdata[LP_W-1:0];
                    CFG_ALPHA_GROUND:  alpha_ground  <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ALPHA_AIR:     alpha_air     <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ALPHA_PREFILT: alpha_prefilt <= cfg_wdata[ALPHA_W-1:0];
                    CFG_ACCEL_MIN:     accel_min     <= cfg_wdata[ACCLIM_W-1:0];
                    CFG_ACCEL_MAX:     accel_max     <= cfg_wdata[ACCLIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_grav_q.push_back(filter_step(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready) begin
                if (expected_grav_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h / %b",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_grav_q.pop_front();
                    for (int i = 0; i < 5; i++)
                        if (m_tdata[16*i +: 16] !== want.fields[16*i +: 16]) begin
                            $display("%0t: %s expected %0d got %0d", $time, field_name[i],
                                     $signed(want.fields[16*i +: 16]),
                                     $signed(m_tdata[16*i +: 16]));
                            mismatch_count++;
                        end
                    if (m_tuser[0] !== want.fused) begin
                        $display("%0t: fused expected %b got %b", $time, want.fused, m_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
        end
        pending = expected_grav_q.size();
    end

endmodule

// ===== dv/gravity_vector_complementary_filter_tb.sv =====
// top of the gravity vector filter bench: clock, reset, register phases,
// directed and random imu samples, receiver backpressure and the verdict
// depends on gvcf_pkg, the filter rtl and gvcf_checker
`timescale 1ns / 1ps

module gravity_vector_complementary_filter_tb;
    import gvcf_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // rate_x, rate_y, rate_z (24 bit each), acc_x, acc_y, acc_z (16 bit each)
    logic [119:0]          s_tdata = '0;
    // on_ground
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    // grav_x, grav_y, grav_z, tilt_a, tilt_b (16 bit each)
    logic [79:0]           m_tdata;
    // fused
    logic [0:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending;
    bit calm = 1'b0;     // no idling on either side in the closing phase
    int ready_hold = 0;

    // 4 ns clock period
    always #2 aclk = ~aclk;

    gravity_vector_complementary_filter i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    gvcf_checker i_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_we, .cfg_index, .cfg_wdata,
        .mismatch_count, .pending
    );

    // receiver stalls in bursts of random length, except in the closing phase
    always @(negedge aclk) begin
        if (calm) begin
            m_tready = 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_tready = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            ready_hold = $urandom_range(1, 9) - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // one imu sample request; valid stays high into the next request unless a gap follows
    task automatic send_sample(input logic [23:0] rx, ry, rz,
                               input logic [15:0] ax, ay, az, input logic gnd);
        s_tdata  = {az, ay, ax, rz, ry, rx};
        s_tuser  = gnd;
        s_tvalid = 1'b1;
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
    endtask

    function automatic logic [23:0] small_rate();
        return 24'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic random_sample();
        logic [15:0] acc [3];
        int dom;
        if ($urandom_range(0, 99) < 15) begin
            // noise: every bit of every field free
            send_sample(24'($urandom), 24'($urandom), 24'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        end else begin
            // near 1 g with one dominant axis, a few off the window
            dom = $urandom_range(0, 2);
            foreach (acc[i])
                acc[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
            acc[dom] = 16'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2500, 5000)));
            if ($urandom_range(0, 9) == 0)
                send_sample(24'($urandom), 24'($urandom), 24'($urandom),
                            acc[0], acc[1], acc[2], 1'($urandom_range(0, 1)));
            else
                send_sample(small_rate(), small_rate(), small_rate(), acc[0], acc[1], acc[2],
                            1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // new register setting, only once every result of the last phase is back
    task automatic new_setting(input int lp, ag, aa, apf, amin, amax);
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        write_reg(CFG_LOOP_PERIOD, CFG_DATA_W'(lp));
        write_reg(CFG_ALPHA_GROUND, CFG_DATA_W'(ag));
        write_reg(CFG_ALPHA_AIR, CFG_DATA_W'(aa));
        write_reg(CFG_ALPHA_PREFILT, CFG_DATA_W'(apf));
        write_reg(CFG_ACCEL_MIN, CFG_DATA_W'(amin));
        write_reg(CFG_ACCEL_MAX, CFG_DATA_W'(amax));
        // indexes past the list must be ignored
        write_reg(3'd6, CFG_DATA_W'($urandom));
        write_reg(3'd7, CFG_DATA_W'($urandom));
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed samples at reset settings: level, rate and accel extremes
        send_sample(0, 0, 0, 0, 0, 16'd4096, 1);
        send_sample(0, 0, 0, 0, 0, 16'd4096, 0);
        send_sample(24'h7fffff, 0, 0, 0, 0, 16'd4096, 1);
        send_sample(24'h800000, 0, 0, 0, 0, 16'd4096, 1);
        send_sample(0, 24'h7fffff, 0, 0, 0, 16'd4096, 0);
        send_sample(0, 24'h800000, 0, 0, 0, 16'd4096, 0);
        send_sample(0, 0, 24'h7fffff, 16'd4096, 0, 0, 0);
        send_sample(0, 0, 24'h800000, 16'd4096, 0, 0, 1);
        send_sample(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        send_sample(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0);
        send_sample(0, 0, 0, 0, 0, 0, 1);
        send_sample(0, 0, 0, 16'd4096, 0, 0, 0);
        send_sample(0, 0, 0, 0, -16'sd4096, 0, 1);
        send_sample(0, 0, 0, 0, 0, -16'sd4096, 1);
        send_sample(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        send_sample(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'h8000, 0);
        repeat (170) random_sample();

        // blend takes the accel whole on ground, air blend half; wide window
        new_setting(1, 0, 32768, 0, 0, 32767);
        send_sample(0, 0, 0, 0, 16'd4096, 0, 1);         // x and z estimate both zero
        send_sample(0, 0, 0, 0, 0, -16'sd4096, 1);       // estimate points down
        send_sample(0, 0, 0, 0, 0, 16'd4096, 0);         // air blend cancels to zero vector
        send_sample(0, 0, 0, 0, 0, 16'd4096, 0);
        repeat (180) random_sample();

        // longest loop period, maximum retention everywhere
        new_setting(16777215, 65535, 65535, 65535, 2867, 5325);
        repeat (185) random_sample();

        // no rotation and an empty window
        new_setting(0, 32768, 40000, 0, 5000, 3000);
        send_sample(24'h7fffff, 24'h800000, 24'h7fffff, 0, 0, 16'd4096, 0);
        repeat (185) random_sample();

        new_setting(100000, 65535, 0, 40000, 1, 32766);
        repeat (185) random_sample();

        new_setting($urandom_range(1, 16777215), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 3500), $urandom_range(4500, 32767));
        repeat (185) random_sample();

        // closing phase back at reset values, both sides run flat out
        new_setting(16777, 64880, 65470, 0, 2867, 5325);
        calm = 1'b1;
        repeat (185) random_sample();

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (500) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== gravity_vector_complementary_filter.f =====
+incdir+rtl
rtl/gvcf_pkg.sv
rtl/gvcf_sqrt.sv
rtl/gvcf_div.sv
rtl/gvcf_cordic.sv
rtl/gravity_vector_complementary_filter.sv
dv/gvcf_checker.sv
dv/gravity_vector_complementary_filter_tb.sv
